// ===== src/rett_pkg.sv =====
package rett_pkg;

  // Default sizing
  localparam int PENDING_DEPTH_DEF = 63;
  localparam int SAMPLE_BITS_DEF   = 16;

  // Result queue at the back end
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_LVL_W = $clog2(OQ_DEPTH + 1);

  // Command kinds handed from the front to the back
  localparam logic [1:0] KIND_KEEP  = 2'd0;  // content: flush pending unchanged, then sample
  localparam logic [1:0] KIND_TRIM  = 2'd1;  // flush pending as -1, then sample as -1
  localparam logic [1:0] KIND_QUEUE = 2'd2;  // park sample in pending store

  typedef struct packed {
    logic [1:0] kind;
    logic       row_end;
  } cmd_ctrl_t;

endpackage

// ===== src/rett_ram.sv =====
module rett_ram import rett_pkg::*; #(
  parameter int WIDTH  = 17,
  parameter int DEPTH  = 63,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rett_front.sv =====
module rett_front import rett_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [SAMPLE_BITS:0] in_sample,
  input  logic                 in_row_end,
  output logic                 in_full,
  input  logic [SAMPLE_BITS-1:0] thr,
  output logic                 cmd_valid,
  output logic [SAMPLE_BITS:0] cmd_smp,
  output cmd_ctrl_t            cmd_ctrl,
  input  logic                 cmd_take
);

  localparam int SW = SAMPLE_BITS + 1;

  logic        seen_r, seen_nxt;
  logic [SW-1:0] cq_smp_r [2];
  cmd_ctrl_t     cq_ctrl_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cq_cnt_r, cq_cnt_nxt;
  logic        accept, content;
  cmd_ctrl_t   ctrl_new;

  assign in_full = (cq_cnt_r == 2'd2);
  assign accept  = in_push && !in_full;

  // Content: non-negative and strictly above threshold
  assign content = !in_sample[SW-1] && (in_sample[SAMPLE_BITS-1:0] > thr);

  // Classify the item against the row state
  always_comb begin
    ctrl_new.row_end = in_row_end;
    if (content) begin
      ctrl_new.kind = KIND_KEEP;
    end else if (in_row_end || !seen_r) begin
      ctrl_new.kind = KIND_TRIM;
    end else begin
      ctrl_new.kind = KIND_QUEUE;
    end
    if (!accept) begin
      seen_nxt = seen_r;
    end else if (in_row_end) begin
      seen_nxt = 1'b0;
    end else begin
      seen_nxt = seen_r || content;
    end
  end

  // Two-entry command queue toward the back
  assign cq_cnt_nxt = cq_cnt_r + {1'b0, accept} - {1'b0, cmd_take};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= 1'b0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cq_cnt_r <= 2'd0;
    end else begin
      seen_r   <= seen_nxt;
      cq_cnt_r <= cq_cnt_nxt;
      if (accept) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (cmd_take) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cq_smp_r[wr_ptr_r]  <= in_sample;
      cq_ctrl_r[wr_ptr_r] <= ctrl_new;
    end
  end

  assign cmd_valid = (cq_cnt_r != 2'd0);
  assign cmd_smp   = cq_smp_r[rd_ptr_r];
  assign cmd_ctrl  = cq_ctrl_r[rd_ptr_r];

endmodule

// ===== src/rett_outq.sv =====
module rett_outq import rett_pkg::*; #(
  parameter int WIDTH = 19
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    wdata,
  input  logic                pop,
  output logic [WIDTH-1:0]    rdata,
  output logic                empty,
  output logic [OQ_LVL_W-1:0] level
);

  logic [WIDTH-1:0]    mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_r, rd_r;
  logic [OQ_LVL_W-1:0] cnt_r, cnt_nxt;
  logic                do_pop;

  assign empty  = (cnt_r == '0);
  assign do_pop = pop && !empty;
  assign level  = cnt_r;

  // Back end only pushes when it holds a free slot
  assign cnt_nxt = cnt_r + OQ_LVL_W'(push) - OQ_LVL_W'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_r];

endmodule

// ===== src/rett_back.sv =====
module rett_back import rett_pkg::*; #(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  input  logic [SAMPLE_BITS:0]   cmd_smp,
  input  cmd_ctrl_t              cmd_ctrl,
  output logic                   cmd_take,
  input  logic [OQ_LVL_W-1:0]    oq_level,
  output logic                   oq_push,
  output logic [SAMPLE_BITS+2:0] oq_wdata
);

  localparam int SW    = SAMPLE_BITS + 1;
  localparam int PTR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int FL_W  = OQ_LVL_W + 1;

  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cnt_nz, cnt_full, can_issue;
  logic             iss, iss_ram, iss_end, iss_ovf, pop_head, push_tail;
  logic [SW-1:0]    iss_smp;
  logic             s1_valid_r, s1_ram_r, s1_end_r, s1_ovf_r;
  logic [SW-1:0]    s1_smp_r;
  logic [SW-1:0]    ram_rdata;

  assign cnt_nz   = (cnt_r != '0);
  assign cnt_full = (cnt_r == CNT_W'(PENDING_DEPTH));

  // Credit: result queue plus the read stage must leave a free slot
  assign can_issue = (FL_W'(oq_level) + FL_W'(s1_valid_r)) < FL_W'(OQ_DEPTH);

  // Sequencer: one result or one pending write per cycle, results only while the credit allows
  always_comb begin
    cmd_take  = 1'b0;
    iss       = 1'b0;
    iss_ram   = 1'b0;
    iss_smp   = cmd_smp;
    iss_end   = 1'b0;
    iss_ovf   = 1'b0;
    pop_head  = 1'b0;
    push_tail = 1'b0;
    if (cmd_valid) begin
      unique case (cmd_ctrl.kind)
        KIND_KEEP: begin
          if (can_issue) begin
            iss = 1'b1;
            if (cnt_nz) begin
              iss_ram  = 1'b1;
              pop_head = 1'b1;
            end else begin
              iss_end  = cmd_ctrl.row_end;
              cmd_take = 1'b1;
            end
          end
        end
        KIND_TRIM: begin
          if (can_issue) begin
            iss     = 1'b1;
            iss_smp = '1;
            if (cnt_nz) begin
              pop_head = 1'b1;
            end else begin
              iss_end  = cmd_ctrl.row_end;
              cmd_take = 1'b1;
            end
          end
        end
        KIND_QUEUE: begin
          // Full store: release the oldest early, park the sample next cycle
          if (cnt_full) begin
            if (can_issue) begin
              iss      = 1'b1;
              iss_ram  = 1'b1;
              iss_ovf  = 1'b1;
              pop_head = 1'b1;
            end
          end else begin
            push_tail = 1'b1;
            cmd_take  = 1'b1;
          end
        end
        default: begin
          cmd_take = 1'b1;
        end
      endcase
    end
  end

  // Circular pointers over the pending store
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (pop_head) begin
      head_nxt = (head_r == PTR_W'(PENDING_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (push_tail) begin
      tail_nxt = (tail_r == PTR_W'(PENDING_DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    cnt_nxt = cnt_r - CNT_W'(pop_head) + CNT_W'(push_tail);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      cnt_r      <= cnt_nxt;
      s1_valid_r <= iss;
    end
  end

  // Read stage payload, waits on the registered RAM read
  always_ff @(posedge clk) begin
    s1_ram_r <= iss_ram;
    s1_smp_r <= iss_smp;
    s1_end_r <= iss_end;
    s1_ovf_r <= iss_ovf;
  end

  rett_ram #(
    .WIDTH (SW),
    .DEPTH (PENDING_DEPTH)
  ) u_pend (
    .clk   (clk),
    .we    (push_tail),
    .waddr (tail_r),
    .wdata (cmd_smp),
    .re    (iss_ram),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign oq_push  = s1_valid_r;
  assign oq_wdata = {(s1_ram_r ? ram_rdata : s1_smp_r), s1_end_r, s1_ovf_r};

endmodule

// ===== src/row_edge_threshold_trim_core.sv =====
// Row edge trim. Samples enter through a queue-style port (push/full) with a flag on the
// last sample of each row; results leave through another (empty/pop). A sample counts as
// content when it is non-negative and strictly above cfg_wdata's threshold. The front
// part classifies each item and posts it to a two-entry command queue; the back part
// keeps non-content samples that follow content in a pending store (one RAM with a write
// port and a registered read port, PENDING_DEPTH deep) and replays them unchanged on the
// next content sample or as -1 at row end. Rate: the front takes one item per cycle while
// the command queue has room. The back part produces at most one result per cycle, paced
// by the one read port of the pending store: a parked sample gives no result, a flush
// of N pending samples gives N results and then the sample's own, and an overflow
// release gives the oldest sample before the new one is parked. With results popped each
// cycle the back part gives one result per cycle while not parking. An item passes the
// command queue, read stage and result queue. Write the threshold only while idle.
module row_edge_threshold_trim_core import rett_pkg::*; #(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [SAMPLE_BITS-1:0] cfg_wdata,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [SAMPLE_BITS:0]   in_sample_in,
  input  logic                   in_row_end_in,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [SAMPLE_BITS:0]   out_sample_out,
  output logic                   out_row_end_out,
  output logic                   out_pending_overflow
);

  localparam int RW = SAMPLE_BITS + 3;

  logic [SAMPLE_BITS-1:0] thr_r;
  logic                   cmd_valid, cmd_take, oq_push;
  logic [SAMPLE_BITS:0]   cmd_smp;
  cmd_ctrl_t              cmd_ctrl;
  logic [OQ_LVL_W-1:0]    oq_level;
  logic [RW-1:0]          oq_wdata, oq_rdata;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  rett_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_sample  (in_sample_in),
    .in_row_end (in_row_end_in),
    .in_full    (in_full),
    .thr        (thr_r),
    .cmd_valid  (cmd_valid),
    .cmd_smp    (cmd_smp),
    .cmd_ctrl   (cmd_ctrl),
    .cmd_take   (cmd_take)
  );

  rett_back #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_smp   (cmd_smp),
    .cmd_ctrl  (cmd_ctrl),
    .cmd_take  (cmd_take),
    .oq_level  (oq_level),
    .oq_push   (oq_push),
    .oq_wdata  (oq_wdata)
  );

  rett_outq #(
    .WIDTH (RW)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .empty (out_empty),
    .level (oq_level)
  );

  assign out_sample_out       = oq_rdata[RW-1:2];
  assign out_row_end_out      = oq_rdata[1];
  assign out_pending_overflow = oq_rdata[0];

endmodule

// ===== src/rett_checker.sv =====
module rett_checker import rett_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_empty,
  input logic                   out_pop,
  input logic [SAMPLE_BITS:0]   out_sample_out,
  input logic                   out_row_end_out,
  input logic                   out_pending_overflow
);

  // Nothing waits right after reset
  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> out_empty)
    else $error("result waiting right after reset");

  // An early release is never the last result of a row
  a_ovf_not_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pending_overflow) |-> !out_row_end_out)
    else $error("overflow item flagged as row end");

  // A waiting item holds until popped
  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_sample_out) && $stable(out_row_end_out)
       && $stable(out_pending_overflow)))
    else $error("waiting result changed before pop");

  // After a popped overflow release, the next waiting item is never a row end flagged as overflow
  a_ovf_then_more: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pending_overflow && out_pop) |=> !(!out_empty && out_row_end_out
      && out_pending_overflow))
    else $error("overflow item followed by flagged row end");

endmodule

bind row_edge_threshold_trim_core rett_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_rett_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_empty            (out_empty),
  .out_pop              (out_pop),
  .out_sample_out       (out_sample_out),
  .out_row_end_out      (out_row_end_out),
  .out_pending_overflow (out_pending_overflow)
);
